FILE: sv/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

    // field widths
    localparam int W_CH   = 2;
    localparam int W_EST  = 40;
    localparam int W_ERR  = 32;
    localparam int W_Q    = 24;
    localparam int W_CFG  = 40;
    localparam int W_GAIN = 25;   // gain Q1.24, range 0..1.0 inclusive
    localparam int W_DEN  = W_ERR + 1;
    localparam int W_MLO  = 21;   // low slice fed to the shared multiplier
    localparam int W_PROD = W_GAIN + W_MLO;

    localparam int CHANNELS_DEF = 4;

    // reset values and constants
    localparam logic signed [W_EST-1:0] EST_RESET = 40'sd6640435200;  // 101325.0
    localparam logic [W_ERR-1:0]        ERR_RESET = 32'd16777216;     // 1.0
    localparam logic [W_Q-1:0]          Q_RESET   = 24'd167772;       // 0.01
    localparam logic [W_GAIN-1:0]       GAIN_ONE  = 25'd16777216;     // 1.0

    // multiplier sequence phases
    localparam logic [2:0] PH_STEP_LO = 3'd0;
    localparam logic [2:0] PH_STEP_HI = 3'd1;
    localparam logic [2:0] PH_T1_LO   = 3'd2;
    localparam logic [2:0] PH_T1_HI   = 3'd3;
    localparam logic [2:0] PH_T2_LO   = 3'd4;
    localparam logic [2:0] PH_T2_HI   = 3'd5;
    localparam logic [2:0] PH_LAST    = 3'd6;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_REINIT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_MNOISE = 2'd0,
        CFG_SERR   = 2'd1,
        CFG_SEST   = 2'd2,
        CFG_QFACT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [W_ERR-1:0] num;
        logic [W_DEN-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [W_GAIN-1:0] quot;
    } t_div_rsp;

endpackage

FILE: sv/skf_ifs.sv
`timescale 1ns / 1ps

// measurement / reinit word
interface skf_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [skf_pkg::W_CH-1:0]           channel;
    logic signed [skf_pkg::W_EST-1:0]   measurement;

    modport source (output valid, operation, channel, measurement, input ready);
    modport sink   (input valid, operation, channel, measurement, output ready);
endinterface

// result word
interface skf_out_if;
    logic                               valid;
    logic                               ready;
    logic [skf_pkg::W_CH-1:0]           channel_out;
    logic signed [skf_pkg::W_EST-1:0]   estimate_out;
    logic [skf_pkg::W_ERR-1:0]          error_out;

    modport source (output valid, channel_out, estimate_out, error_out, input ready);
    modport sink   (input valid, channel_out, estimate_out, error_out, output ready);
endinterface

// register write word
interface skf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         index;
    logic [skf_pkg::W_CFG-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/skf_div.sv
`timescale 1ns / 1ps

// Radix-2 restoring divider for the gain: quot = floor(num * 2^24 / den).
// Requires num <= den, so the quotient fits 25 bits. den == 0 gives 0.
module skf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_div_req i_req,
    output skf_pkg::t_div_rsp o_rsp
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(W_GAIN);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [W_DEN:0]       r_rem;
    logic [W_DEN-1:0]     r_den;
    logic [W_GAIN-1:0]    r_quot;
    logic                 r_zero;

    logic                 w_ge;
    logic [W_DEN:0]       w_diff;
    logic [W_DEN-1:0]     w_rem;

    // one quotient bit per cycle
    assign w_ge   = r_rem >= {1'b0, r_den};
    assign w_diff = r_rem - {1'b0, r_den};
    assign w_rem  = w_ge ? w_diff[W_DEN-1:0] : r_rem[W_DEN-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W_GAIN - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= (W_DEN+1)'(i_req.num);
            r_den  <= i_req.den;
            r_zero <= (i_req.den == '0);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {w_rem, 1'b0};
            r_quot <= {r_quot[W_GAIN-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_zero ? '0 : r_quot;

endmodule

FILE: sv/scalar_kalman_filter_adaptive_q.sv
`timescale 1ns / 1ps

// Port        Dir  Handshake     Word
// i_in        in   valid/ready   operation, channel, measurement
// o_out       out  valid/ready   channel_out, estimate_out, error_out
// i_cfg       in   valid/ready   index, data (ready high out of reset)
//
// One word at a time. An update goes from accept to the result handshake through load,
// the radix-2 gain divider (25 quotient bits and the done cycle), the phases of the
// shared 25x21 multiplier, then write-back and the output register. A reinit or an
// out-of-range channel goes from load straight to write-back. Reset is synchronous; per-channel
// valid bits make unwritten entries read as their reset values, no clearing pass.
// A stalled output holds the finished word in the write-back state;
// the output register lets the next word be accepted while a result waits.
module scalar_kalman_filter_adaptive_q #(
    parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    skf_in_if.sink    i_in,
    skf_out_if.source o_out,
    skf_cfg_if.sink   i_cfg
);
    import skf_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = ((AW > W_CH) ? AW : W_CH) + 1;

    // configuration registers
    logic [W_ERR-1:0]        r_mnoise;
    logic [W_ERR-1:0]        r_serr;
    logic signed [W_EST-1:0] r_sest;
    logic [W_Q-1:0]          r_q;

    // control
    t_state                  r_state, n_state;
    logic [2:0]              r_ph;
    logic                    w_in_rdy, w_in_acc;
    logic                    w_fin_go, w_we, w_out_free;
    logic                    w_div_start;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    // item and state memory
    logic [W_EST+W_ERR-1:0]  r_mem [CHANNELS];
    logic [W_EST+W_ERR-1:0]  r_rd;
    logic [CHANNELS-1:0]     r_vld;
    logic                    r_hit;
    logic [CW-1:0]           w_ch_in;
    logic [AW-1:0]           w_idx;
    logic [AW-1:0]           r_idx;
    logic                    r_inrange;
    t_op                     r_op;
    logic [W_CH-1:0]         r_ch;
    logic signed [W_EST-1:0] r_z;

    // update datapath
    logic [W_ERR-1:0]        w_e;
    logic signed [W_EST-1:0] w_x;
    logic [W_ERR-1:0]        r_e;
    logic signed [W_EST-1:0] r_x;
    logic [W_EST:0]          r_d;
    logic [W_EST:0]          w_dneg;
    logic                    r_neg;
    logic [W_EST-1:0]        r_mag;
    logic [W_GAIN-1:0]       r_g;
    logic [W_GAIN-1:0]       w_ma;
    logic [W_MLO-1:0]        w_mb;
    logic [W_PROD-1:0]       r_prod;
    logic [2:0]              w_pp;
    logic                    w_first;
    logic [63:0]             r_acc;
    logic [63:0]             w_sum;
    logic [W_EST-1:0]        r_step;
    logic [W_ERR-1:0]        r_t1;
    logic [47:0]             r_t2;
    logic [48:0]             w_ne;
    logic [W_EST:0]          w_xn;
    logic signed [W_EST-1:0] n_est;
    logic [W_ERR-1:0]        n_err;

    // output register
    logic                    r_ov;
    logic [W_CH-1:0]         r_och;
    logic signed [W_EST-1:0] r_oest;
    logic [W_ERR-1:0]        r_oerr;

    // configuration writes, ready whenever out of reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mnoise <= ERR_RESET;
            r_serr   <= ERR_RESET;
            r_sest   <= EST_RESET;
            r_q      <= Q_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MNOISE: r_mnoise <= i_cfg.data[W_ERR-1:0];
                CFG_SERR:   r_serr   <= i_cfg.data[W_ERR-1:0];
                CFG_SEST:   r_sest   <= signed'(i_cfg.data[W_EST-1:0]);
                CFG_QFACT:  r_q      <= i_cfg.data[W_Q-1:0];
                default: ;
            endcase
        end
    end

    // handshake and channel decode
    assign i_in.ready = w_in_rdy;
    assign w_in_acc   = i_in.valid && w_in_rdy;
    assign w_ch_in    = CW'(i_in.channel);
    assign w_idx      = w_ch_in[AW-1:0];
    assign w_out_free = !r_ov || o_out.ready;
    assign w_we       = w_fin_go && r_inrange;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        w_in_rdy    = 1'b0;
        w_div_start = 1'b0;
        w_fin_go    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_rdy = i_rst_n;
                if (i_in.valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_op == OP_UPDATE && r_inrange) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_ph == PH_LAST) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_fin_go = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // valid bits and multiplier phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ph  <= '0;
        end else begin
            if (w_we) r_vld[r_idx] <= 1'b1;
            if (r_state == ST_MUL) begin
                r_ph <= r_ph + 1'b1;
            end else begin
                r_ph <= '0;
            end
        end
    end

    // state memory; one item in flight, so read and write never overlap
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_idx] <= {n_est, n_err};
        if (w_in_acc) begin
            r_rd  <= r_mem[w_idx];
            r_hit <= r_vld[w_idx];
        end
    end

    // capture the word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= t_op'(i_in.operation);
            r_ch      <= i_in.channel;
            r_z       <= i_in.measurement;
            r_idx     <= w_idx;
            r_inrange <= w_ch_in < CW'(CHANNELS);
        end
    end

    // entry read: unwritten entries hold reset values
    assign w_e = r_hit ? r_rd[W_ERR-1:0] : ERR_RESET;
    assign w_x = r_hit ? signed'(r_rd[W_EST+W_ERR-1:W_ERR]) : EST_RESET;

    assign w_div_req.start = w_div_start;
    assign w_div_req.num   = w_e;
    assign w_div_req.den   = {1'b0, w_e} + {1'b0, r_mnoise};

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // shared multiplier operands
    always_comb begin
        case (r_ph)
            PH_STEP_LO: begin w_ma = r_g;             w_mb = r_mag[W_MLO-1:0]; end
            PH_STEP_HI: begin w_ma = r_g;             w_mb = W_MLO'(r_mag[W_EST-1:W_MLO]); end
            PH_T1_LO:   begin w_ma = GAIN_ONE - r_g;  w_mb = r_e[W_MLO-1:0]; end
            PH_T1_HI:   begin w_ma = GAIN_ONE - r_g;  w_mb = W_MLO'(r_e[W_ERR-1:W_MLO]); end
            PH_T2_LO:   begin w_ma = W_GAIN'(r_q);    w_mb = r_step[W_MLO-1:0]; end
            PH_T2_HI:   begin w_ma = W_GAIN'(r_q);    w_mb = W_MLO'(r_step[W_EST-1:W_MLO]); end
            default:    begin w_ma = '0;              w_mb = '0; end
        endcase
    end

    // accumulate the product of the previous phase
    assign w_pp    = r_ph - 3'd1;
    assign w_first = (w_pp == PH_STEP_LO) || (w_pp == PH_T1_LO) || (w_pp == PH_T2_LO);
    assign w_sum   = w_first ? 64'(r_prod) : (r_acc + (64'(r_prod) << W_MLO));
    assign w_dneg  = ~r_d + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_e <= w_e;
            r_x <= w_x;
            r_d <= {r_z[W_EST-1], r_z} - {w_x[W_EST-1], w_x};
        end
        if (r_state == ST_DIV) begin
            r_neg <= r_d[W_EST];
            r_mag <= r_d[W_EST] ? w_dneg[W_EST-1:0] : r_d[W_EST-1:0];
            if (w_div_rsp.done) r_g <= w_div_rsp.quot;
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_ma * w_mb;
            if (r_ph != PH_STEP_LO) begin
                r_acc <= w_sum;
                case (w_pp)
                    PH_STEP_HI: r_step <= w_sum[63:24];
                    PH_T1_HI:   r_t1   <= w_sum[55:24];
                    PH_T2_HI:   r_t2   <= w_sum[63:16];
                    default: ;
                endcase
            end
        end
    end

    // new estimate and error
    assign w_xn = r_neg ? ({r_x[W_EST-1], r_x} - {1'b0, r_step})
                        : ({r_x[W_EST-1], r_x} + {1'b0, r_step});
    assign w_ne = 49'(r_t1) + 49'(r_t2);

    always_comb begin
        if (!r_inrange) begin
            n_est = '0;
            n_err = '0;
        end else if (r_op == OP_REINIT) begin
            n_est = r_sest;
            n_err = r_serr;
        end else begin
            n_est = signed'(w_xn[W_EST-1:0]);
            n_err = (w_ne[48:W_ERR] != '0) ? '1 : w_ne[W_ERR-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fin_go) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_och  <= r_ch;
            r_oest <= n_est;
            r_oerr <= n_err;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.channel_out  = r_och;
    assign o_out.estimate_out = r_oest;
    assign o_out.error_out    = r_oerr;

    // gain never exceeds 1.0 since E <= E + M
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_g <= GAIN_ONE))
        else $error("gain above 1.0");

    // the step never overshoots the measurement
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_op == OP_UPDATE && r_inrange) |-> (r_step <= r_mag))
        else $error("step larger than innovation");

    // updated estimate lies between old estimate and measurement
    a_est_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && r_op == OP_UPDATE && r_inrange) |->
        ((r_neg && n_est <= r_x && n_est >= r_z) ||
         (!r_neg && n_est >= r_x && n_est <= r_z)))
        else $error("estimate left its interval");

    // a finished word never overwrites an untaken result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_oest) && $stable(r_oerr)))
        else $error("result overwritten while stalled");

endmodule

FILE: verif/scalar_kalman_filter_adaptive_q_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_filter_adaptive_q_tb;
    import skf_pkg::*;

    localparam int CHAN         = CHANNELS_DEF;
    localparam int RANDOM_WORDS = 1250;
    localparam int PHASES       = 10;
    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving on any port
    localparam int HOLD_CYCLES  = 300;    // long result back-pressure
    localparam int DRAIN_CYCLES = 64;

    localparam logic signed [W_EST-1:0] EST_MAX = {1'b0, {(W_EST-1){1'b1}}};
    localparam logic signed [W_EST-1:0] EST_MIN = {1'b1, {(W_EST-1){1'b0}}};

    typedef struct packed {
        logic [W_CH-1:0]         channel;
        logic signed [W_EST-1:0] estimate;
        logic [W_ERR-1:0]        error;
    } t_kf_word;

    // tracks filter state per channel and the result words still owed
    class kalman_scoreboard;
        logic [W_ERR-1:0]        noise;
        logic [W_ERR-1:0]        start_err;
        logic signed [W_EST-1:0] start_est;
        logic [W_Q-1:0]          qfact;
        logic signed [W_EST-1:0] chan_est[CHAN];
        logic [W_ERR-1:0]        chan_err[CHAN];
        t_kf_word                expected_estimates[$];
        int                      mismatches;

        function new();
            noise      = ERR_RESET;
            start_err  = ERR_RESET;
            start_est  = EST_RESET;
            qfact      = Q_RESET;
            mismatches = 0;
            for (int i = 0; i < CHAN; i++) begin
                chan_est[i] = EST_RESET;
                chan_err[i] = ERR_RESET;
            end
        endfunction

        function void load_register(t_cfg_idx idx, logic [W_CFG-1:0] data);
            case (idx)
                CFG_MNOISE: noise     = data[W_ERR-1:0];
                CFG_SERR:   start_err = data[W_ERR-1:0];
                CFG_SEST:   start_est = data[W_EST-1:0];
                CFG_QFACT:  qfact     = data[W_Q-1:0];
                default: ;
            endcase
        endfunction

        // one filter step on the addressed channel
        function void predict_update(t_op op, logic [W_CH-1:0] ch,
                                     logic signed [W_EST-1:0] z);
            t_kf_word                w;
            logic [127:0]            e, s, gain, mag, step, t1, t2, sum;
            logic signed [W_EST:0]   diff;
            logic [W_EST:0]          absd;
            logic signed [W_EST-1:0] x;
            if (op == OP_REINIT) begin
                chan_est[ch] = start_est;
                chan_err[ch] = start_err;
            end else begin
                x    = chan_est[ch];
                e    = 128'(chan_err[ch]);
                s    = e + 128'(noise);
                // gain Q1.24, zero when E + M is zero
                gain = (s == 0) ? 128'd0 : (e << 24) / s;
                diff = $signed({z[W_EST-1], z}) - $signed({x[W_EST-1], x});
                absd = diff[W_EST] ? -diff : diff;
                mag  = 128'(absd);
                // step truncates toward zero
                step = (mag * gain) >> 24;
                t1   = (((128'd1 << 24) - gain) * e) >> 24;
                t2   = (step * 128'(qfact)) >> 16;
                sum  = t1 + t2;
                // new estimate lies between old estimate and measurement
                chan_est[ch] = diff[W_EST] ? x - step[W_EST-1:0] : x + step[W_EST-1:0];
                chan_err[ch] = (sum > 128'hFFFF_FFFF) ? '1 : sum[W_ERR-1:0];
            end
            w.channel  = ch;
            w.estimate = chan_est[ch];
            w.error    = chan_err[ch];
            expected_estimates.push_back(w);
        endfunction

        function void check_estimate(logic [W_CH-1:0] ch, logic signed [W_EST-1:0] est,
                                     logic [W_ERR-1:0] err);
            t_kf_word w;
            if (expected_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: ch %0d est %0d err %0d", ch, est, err);
                return;
            end
            w = expected_estimates.pop_front();
            if (ch !== w.channel || est !== w.estimate || err !== w.error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected ch %0d est %0d err %0d, ",
                              "got ch %0d est %0d err %0d"},
                             w.channel, w.estimate, w.error, ch, est, err);
            end
        endfunction

        function int pending();
            return expected_estimates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    skf_in_if  in_if ();
    skf_out_if out_if ();
    skf_cfg_if cfg_if ();

    scalar_kalman_filter_adaptive_q u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    kalman_scoreboard sb;
    int  in_idle_max;
    int  out_idle_max;
    bit  hold_output;
    int  stall_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one measurement word, note it once accepted
    task automatic send_word(input t_op op, input logic [W_CH-1:0] ch,
                             input logic signed [W_EST-1:0] meas);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.operation   = op;
        in_if.channel     = ch;
        in_if.measurement = meas;
        do @(posedge i_clk); while (!in_if.ready);
        sb.predict_update(op, ch, meas);
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [W_CFG-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.load_register(idx, data);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // stop offering and let every owed result come back
    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [W_CFG-1:0] pick_register_value();
        logic [W_CFG-1:0] v;
        v = W_CFG'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = {1'b0, {(W_CFG-1){1'b1}}};
            3: v = {1'b1, {(W_CFG-1){1'b0}}};
            4: v[W_ERR-1:0] = ERR_RESET >> $urandom_range(0, 8);   // 1.0 down to 1/256, upper bits junk
            default: ;
        endcase
        return v;
    endfunction

    // mostly measurements close to the tracked estimate
    function automatic logic signed [W_EST-1:0] pick_measurement(logic [W_CH-1:0] ch);
        logic signed [W_EST-1:0] z;
        case ($urandom_range(0, 9))
            0: z = W_EST'({$urandom, $urandom});
            1: z = ($urandom_range(0, 1) == 1) ? EST_MAX : EST_MIN;
            default: z = sb.chan_est[ch] + W_EST'($urandom_range(0, 2097152)) - 40'sd1048576;
        endcase
        return z;
    endfunction

    // result side with random back-pressure
    initial begin : result_sink
        int gap;
        bit held;
        held         = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_output && !held) begin
                held         = 1'b1;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = $urandom_range(0, out_idle_max);
            if (gap > 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_estimate(out_if.channel_out, out_if.estimate_out, out_if.error_out);
            @(negedge i_clk);
        end
    end

    // watchdog on ports going quiet
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [W_CH-1:0] ch;
        t_op             op;
        sb                = new();
        hold_output       = 1'b0;
        in_idle_max       = 2;
        out_idle_max      = 2;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.operation   = OP_UPDATE;
        in_if.channel     = '0;
        in_if.measurement = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_MNOISE;
        cfg_if.data       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: field extremes, no movement, reinit ignoring measurement
        send_word(OP_UPDATE, 2'd0, EST_MAX);
        send_word(OP_UPDATE, 2'd1, EST_MIN);
        send_word(OP_UPDATE, 2'd2, EST_RESET);
        send_word(OP_UPDATE, 2'd3, '0);
        send_word(OP_REINIT, 2'd0, EST_MIN);
        send_word(OP_UPDATE, 2'd0, '1);
        send_word(OP_REINIT, 2'd3, 40'sh55_AAAA_5555);

        // full gain with largest q: error saturates
        wait_idle();
        write_register(CFG_MNOISE, '0);
        write_register(CFG_SERR, '1);
        write_register(CFG_SEST, {1'b1, {(W_CFG-1){1'b0}}});
        write_register(CFG_QFACT, '1);
        send_word(OP_REINIT, 2'd2, '0);
        send_word(OP_UPDATE, 2'd2, EST_MAX);
        send_word(OP_UPDATE, 2'd2, EST_MIN);
        send_word(OP_UPDATE, 2'd1, EST_MAX);

        // E + M zero: gain zero, estimate holds, error clears
        wait_idle();
        write_register(CFG_SERR, '0);
        write_register(CFG_SEST, {1'b0, {(W_CFG-1){1'b1}}});
        send_word(OP_REINIT, 2'd1, '0);
        send_word(OP_UPDATE, 2'd1, EST_MIN);
        send_word(OP_UPDATE, 2'd1, '0);

        // largest M, q zero: the smallest E gives a gain that floors to zero
        wait_idle();
        write_register(CFG_MNOISE, '1);
        write_register(CFG_QFACT, '0);
        write_register(CFG_SERR, 40'd1);
        write_register(CFG_SEST, '0);
        send_word(OP_REINIT, 2'd3, '0);
        send_word(OP_UPDATE, 2'd3, EST_MAX);
        send_word(OP_UPDATE, 2'd3, EST_MIN);
        send_word(OP_UPDATE, 2'd0, EST_MAX);

        // random phases, new settings each phase
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            for (int r = 0; r < 4; r++)
                write_register(t_cfg_idx'(r), pick_register_value());
            case (p % 4)
                0: begin in_idle_max = 16; out_idle_max = 16; end
                1: begin in_idle_max = 0;  out_idle_max = 0;  end
                2: begin in_idle_max = 3;  out_idle_max = 16; end
                default: begin in_idle_max = 16; out_idle_max = 0; end
            endcase
            // results held off while words keep being offered
            if (p == 1)
                hold_output = 1'b1;
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                ch = W_CH'($urandom_range(0, CHAN - 1));
                op = ($urandom_range(0, 11) == 0) ? OP_REINIT : OP_UPDATE;
                send_word(op, ch, pick_measurement(ch));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/skf_pkg.sv
sv/skf_ifs.sv
sv/skf_div.sv
sv/scalar_kalman_filter_adaptive_q.sv
verif/scalar_kalman_filter_adaptive_q_tb.sv
